/* rtl/kcf_pkg.sv */
// Shared types, constants and helpers for the canonical k-mer FracMinHash filter.
package kcf_pkg;

  localparam int K_MAX_DEF = 32;
  localparam int K_W       = 6;
  localparam int WIN_W     = 64;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] REG_WIN_LEN   = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_HASH_SEED = 2'd2;

  localparam logic [K_W-1:0] WIN_LEN_RST   = 6'd31;
  localparam logic [63:0]    THRESHOLD_RST = 64'd18446744073709552;
  localparam logic [63:0]    HASH_SEED_RST = 64'd42;

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MM_N1 = 64'h0000000052dce729;
  localparam logic [63:0] MM_N2 = 64'h0000000038495ab5;

  typedef struct packed {
    logic [WIN_W-1:0] kmer;
    logic [K_W-1:0]   k;
    logic             amb;
  } item_t;

  function automatic logic [7:0] base_letter(input logic [1:0] code);
    logic [7:0] l;
    case (code)
      2'd0:    l = 8'h41;
      2'd1:    l = 8'h43;
      2'd2:    l = 8'h47;
      default: l = 8'h54;
    endcase
    return l;
  endfunction

endpackage

/* rtl/kcf_queue.sv */
// Short request queue between the window front end and the hash engine.
module kcf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  kcf_pkg::item_t        push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output kcf_pkg::item_t        head
);

  kcf_pkg::item_t                 mem_r [kcf_pkg::Q_DEPTH];
  logic [kcf_pkg::Q_AW-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [kcf_pkg::Q_CW-1:0]       cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full    = (cnt_r == kcf_pkg::Q_CW'(kcf_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == kcf_pkg::Q_AW'(kcf_pkg::Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == kcf_pkg::Q_AW'(kcf_pkg::Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

/* rtl/kcf_front.sv */
// Front end: base intake, strand windows, counters and canonical selection.
module kcf_front #(
  parameter int K_MAX = kcf_pkg::K_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_base_char,
  input  logic                   in_record_start,
  input  logic [kcf_pkg::K_W-1:0] win_len,
  input  logic                   q_full,
  output logic                   q_push,
  output kcf_pkg::item_t         q_item
);

  logic [63:0]             fw_r, fw_nxt, rc_r, rc_nxt, fw0, rc0, fw_m, rc_s;
  logic [kcf_pkg::K_W-1:0] bir_r, bir_nxt, bsa_r, bsa_nxt, bir0, bsa0, k;
  logic [kcf_pkg::K_W:0]   bir_inc, bsa_inc;
  logic [6:0]              k2;
  logic [7:0]              c;
  logic [1:0]              code;
  logic                    acgt, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (win_len == '0) begin
      k = kcf_pkg::K_W'(1);
    end else if (win_len > kcf_pkg::K_W'(K_MAX)) begin
      k = kcf_pkg::K_W'(K_MAX);
    end else begin
      k = win_len;
    end
    k2 = {k, 1'b0};
    c  = in_base_char;
    if (c inside {[8'h61:8'h7a]}) begin
      c = c - 8'h20;
    end
    acgt = 1'b1;
    case (c)
      8'h41:   code = 2'd0;
      8'h43:   code = 2'd1;
      8'h47:   code = 2'd2;
      8'h54:   code = 2'd3;
      default: begin
        code = 2'd0;
        acgt = 1'b0;
      end
    endcase
    fw0     = in_record_start ? '0 : fw_r;
    rc0     = in_record_start ? '0 : rc_r;
    bir0    = in_record_start ? '0 : bir_r;
    bsa0    = in_record_start ? '0 : bsa_r;
    fw_nxt  = {fw0[61:0], code};
    rc_nxt  = {2'd3 - code, rc0[63:2]};
    bir_inc = {1'b0, bir0} + 1'b1;
    bsa_inc = {1'b0, bsa0} + 1'b1;
    bir_nxt = (bir_inc < {1'b0, k}) ? bir_inc[kcf_pkg::K_W-1:0] : k;
    if (acgt) begin
      bsa_nxt = (bsa_inc < {1'b0, k}) ? bsa_inc[kcf_pkg::K_W-1:0] : k;
    end else begin
      bsa_nxt = '0;
    end
    fw_m = fw_nxt & ~({64{1'b1}} << k2);
    rc_s = rc_nxt >> (7'd64 - k2);
    q_item.k    = k;
    q_item.amb  = (bsa_nxt < k);
    q_item.kmer = q_item.amb ? '0 : ((rc_s < fw_m) ? rc_s : fw_m);
    q_push      = accept && (bir_nxt == k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= '0;
      rc_r  <= '0;
      bir_r <= '0;
      bsa_r <= '0;
    end else if (accept) begin
      fw_r  <= fw_nxt;
      rc_r  <= rc_nxt;
      bir_r <= bir_nxt;
      bsa_r <= bsa_nxt;
    end
  end

endmodule

/* rtl/kcf_back.sv */
// Back end: sequenced MurmurHash3 x64_128 engine, threshold test and output register.
module kcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  kcf_pkg::item_t       q_head,
  output logic                 q_pop,
  input  logic [63:0]          threshold,
  input  logic [63:0]          hash_seed,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_kmer_code,
  output logic [63:0]          out_hash,
  output logic                 out_is_selected,
  output logic                 out_is_ambiguous
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_A1   = 5'd1;
  localparam logic [4:0] S_A2   = 5'd2;
  localparam logic [4:0] S_H1   = 5'd3;
  localparam logic [4:0] S_B1   = 5'd4;
  localparam logic [4:0] S_B2   = 5'd5;
  localparam logic [4:0] S_H2   = 5'd6;
  localparam logic [4:0] S_TB1  = 5'd7;
  localparam logic [4:0] S_TB2  = 5'd8;
  localparam logic [4:0] S_TA1  = 5'd9;
  localparam logic [4:0] S_TA2  = 5'd10;
  localparam logic [4:0] S_F0   = 5'd11;
  localparam logic [4:0] S_F1   = 5'd12;
  localparam logic [4:0] S_M1A  = 5'd13;
  localparam logic [4:0] S_M2A  = 5'd14;
  localparam logic [4:0] S_M1B  = 5'd15;
  localparam logic [4:0] S_M2B  = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;
  localparam logic [4:0] S_CMP  = 5'd18;

  logic [4:0]              st_r, st_nxt;
  logic [1:0]              mc_r, mc_nxt, blk_r, blk_nxt, nblk_r, nblk_nxt;
  logic [63:0]             h1_r, h1_nxt, h2_r, h2_nxt, t_r, t_nxt, acc_r, acc_nxt;
  logic [63:0]             mx_r, mx_nxt, hv_r, hv_nxt, kmer_r, kmer_nxt;
  logic [63:0]             words_r [4];
  logic [63:0]             words_nxt [4];
  logic [kcf_pkg::K_W-1:0] k_r, k_nxt;
  logic                    ov_r, ov_nxt, sel_r, sel_nxt, amb_r, amb_nxt;
  logic [63:0]             ok_r, ok_nxt, oh_r, oh_nxt;
  logic [63:0]             op, cst, r, aligned, len64, word_rd;
  logic [2:0]              widx;
  logic [7:0]              bytes [32];
  logic [6:0]              k2;
  logic                    is_mul, out_free;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
    return (x << s) | (x >> (64 - s));
  endfunction

  assign out_free         = !ov_r || !out_stall;
  assign out_valid        = ov_r;
  assign out_kmer_code    = ok_r;
  assign out_hash         = oh_r;
  assign out_is_selected  = sel_r;
  assign out_is_ambiguous = amb_r;
  assign r                = acc_r;
  assign len64            = {58'd0, k_r};
  assign k2               = {q_head.k, 1'b0};
  assign aligned          = q_head.kmer << (7'd64 - k2);

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      bytes[i] = (6'(i) < q_head.k) ? kcf_pkg::base_letter(aligned[63-2*i -: 2]) : 8'd0;
    end
    for (int w = 0; w < 4; w++) begin
      for (int j = 0; j < 8; j++) begin
        words_nxt[w][8*j +: 8] = bytes[8*w + j];
      end
    end
  end

  always_comb begin
    is_mul = 1'b1;
    widx   = {blk_r, 1'b0};
    op     = t_r;
    cst    = kcf_pkg::MM_C1;
    case (st_r)
      S_A1, S_TA1: begin
        widx = {blk_r, 1'b0};
        op   = word_rd;
      end
      S_A2, S_TA2: cst = kcf_pkg::MM_C2;
      S_B1, S_TB1: begin
        widx = {blk_r, 1'b1};
        op   = word_rd;
        cst  = kcf_pkg::MM_C2;
      end
      S_B2, S_TB2: cst = kcf_pkg::MM_C1;
      S_M1A: begin
        op  = h1_r ^ (h1_r >> 33);
        cst = kcf_pkg::MM_F1;
      end
      S_M1B: begin
        op  = h2_r ^ (h2_r >> 33);
        cst = kcf_pkg::MM_F1;
      end
      S_M2A, S_M2B: begin
        op  = t_r ^ (t_r >> 33);
        cst = kcf_pkg::MM_F2;
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign word_rd = widx[2] ? 64'd0 : words_r[widx[1:0]];

  always_comb begin
    st_nxt   = st_r;
    mc_nxt   = mc_r;
    blk_nxt  = blk_r;
    nblk_nxt = nblk_r;
    h1_nxt   = h1_r;
    h2_nxt   = h2_r;
    t_nxt    = t_r;
    acc_nxt  = acc_r;
    mx_nxt   = mx_r;
    hv_nxt   = hv_r;
    kmer_nxt = kmer_r;
    k_nxt    = k_r;
    ov_nxt   = ov_r && out_stall;
    ok_nxt   = ok_r;
    oh_nxt   = oh_r;
    sel_nxt  = sel_r;
    amb_nxt  = amb_r;
    q_pop    = 1'b0;
    if (is_mul) begin
      mc_nxt = mc_r + 1'b1;
      case (mc_r)
        2'd0: begin
          acc_nxt = op[31:0] * cst[31:0];
          mx_nxt  = op;
        end
        2'd1: acc_nxt = acc_r + {32'(mx_r[31:0] * cst[63:32]), 32'd0};
        2'd2: acc_nxt = acc_r + {32'(mx_r[63:32] * cst[31:0]), 32'd0};
        default: begin
          case (st_r)
            S_A1, S_TA1: t_nxt = rotl(r, 31);
            S_B1, S_TB1: t_nxt = rotl(r, 33);
            S_A2:        h1_nxt = rotl(h1_r ^ r, 27) + h2_r;
            S_TA2:       h1_nxt = h1_r ^ r;
            S_B2:        h2_nxt = rotl(h2_r ^ r, 31) + h1_r;
            S_TB2:       h2_nxt = h2_r ^ r;
            S_M2A:       h1_nxt = r ^ (r >> 33);
            S_M2B:       h2_nxt = r ^ (r >> 33);
            default:     t_nxt = r;
          endcase
          case (st_r)
            S_A1:    st_nxt = S_A2;
            S_A2:    st_nxt = S_H1;
            S_B1:    st_nxt = S_B2;
            S_B2:    st_nxt = S_H2;
            S_TB1:   st_nxt = S_TB2;
            S_TB2:   st_nxt = S_TA1;
            S_TA1:   st_nxt = S_TA2;
            S_TA2:   st_nxt = S_F0;
            S_M1A:   st_nxt = S_M2A;
            S_M2A:   st_nxt = S_M1B;
            S_M1B:   st_nxt = S_M2B;
            default: st_nxt = S_FIN;
          endcase
        end
      endcase
    end else begin
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_head.amb) begin
              if (out_free) begin
                q_pop   = 1'b1;
                ov_nxt  = 1'b1;
                ok_nxt  = '0;
                oh_nxt  = '0;
                sel_nxt = 1'b0;
                amb_nxt = 1'b1;
              end
            end else begin
              q_pop    = 1'b1;
              kmer_nxt = q_head.kmer;
              k_nxt    = q_head.k;
              h1_nxt   = {32'd0, hash_seed[31:0]};
              h2_nxt   = {32'd0, hash_seed[31:0]};
              blk_nxt  = '0;
              nblk_nxt = q_head.k[5:4];
              st_nxt   = (q_head.k[5:4] != 2'd0) ? S_A1 : S_TB1;
            end
          end
        end
        S_H1: begin
          h1_nxt = (h1_r << 2) + h1_r + kcf_pkg::MM_N1;
          st_nxt = S_B1;
        end
        S_H2: begin
          h2_nxt  = (h2_r << 2) + h2_r + kcf_pkg::MM_N2;
          blk_nxt = blk_r + 1'b1;
          st_nxt  = (blk_r + 1'b1 < nblk_r) ? S_A1 : S_TB1;
        end
        S_F0: begin
          h1_nxt = (h1_r ^ len64) + (h2_r ^ len64);
          h2_nxt = h2_r ^ len64;
          st_nxt = S_F1;
        end
        S_F1: begin
          h2_nxt = h2_r + h1_r;
          st_nxt = S_M1A;
        end
        S_FIN: begin
          hv_nxt = h1_r + h2_r;
          st_nxt = S_CMP;
        end
        S_CMP: begin
          if (out_free) begin
            ov_nxt  = 1'b1;
            ok_nxt  = kmer_r;
            oh_nxt  = hv_r;
            sel_nxt = (hv_r <= threshold);
            amb_nxt = 1'b0;
            st_nxt  = S_IDLE;
          end
        end
        default: st_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      mc_r <= mc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    nblk_r <= nblk_nxt;
    h1_r   <= h1_nxt;
    h2_r   <= h2_nxt;
    t_r    <= t_nxt;
    acc_r  <= acc_nxt;
    mx_r   <= mx_nxt;
    hv_r   <= hv_nxt;
    kmer_r <= kmer_nxt;
    k_r    <= k_nxt;
    ok_r   <= ok_nxt;
    oh_r   <= oh_nxt;
    sel_r  <= sel_nxt;
    amb_r  <= amb_nxt;
    if (q_pop && !q_head.amb) begin
      for (int w = 0; w < 4; w++) begin
        words_r[w] <= words_nxt[w];
      end
    end
  end

`ifndef SYNTHESIS
  a_amb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && amb_r |-> (oh_r == 64'd0) && !sel_r && (ok_r == 64'd0))
    else $error("ambiguous result carries nonzero payload");
  a_idle_mc: assert property (@(posedge clk) disable iff (!rst_n)
    !is_mul |-> (mc_r == 2'd0))
    else $error("multiply step counter active outside a multiply phase");
  a_cmp_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CMP) && out_free |=> (st_r == S_IDLE) && ov_r && !amb_r)
    else $error("hash result not delivered from compare phase");
`endif

endmodule

/* rtl/canonical_kmer_fracminhash_filter.sv */
// Top level of the canonical k-mer FracMinHash filter: config registers, front, queue, hash engine.
// The front end takes one base per cycle while the queue is not full and emits a request for
// every full window into a two-entry queue. The hash engine serves one request at a time: an
// ambiguous window leaves straight from idle once the output register is free, an unambiguous
// one runs the hash on the single shared 32x32 multiplier, which builds each 64-bit multiply
// from three partial products and then one follow-up step. The output register lets the engine
// start the next request while a result waits to be taken.
module canonical_kmer_fracminhash_filter #(
  parameter int K_MAX = kcf_pkg::K_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_base_char,
  input  logic        in_record_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_kmer_code,
  output logic [63:0] out_hash,
  output logic        out_is_selected,
  output logic        out_is_ambiguous,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [kcf_pkg::K_W-1:0] win_len_r;
  logic [63:0]             threshold_r, hash_seed_r;
  logic                    q_full, q_push, q_empty, q_pop;
  kcf_pkg::item_t          q_item, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= kcf_pkg::WIN_LEN_RST;
      threshold_r <= kcf_pkg::THRESHOLD_RST;
      hash_seed_r <= kcf_pkg::HASH_SEED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kcf_pkg::REG_WIN_LEN:   win_len_r   <= cfg_wdata[kcf_pkg::K_W-1:0];
        kcf_pkg::REG_THRESHOLD: threshold_r <= cfg_wdata;
        kcf_pkg::REG_HASH_SEED: hash_seed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kcf_front #(.K_MAX(K_MAX)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_base_char    (in_base_char),
    .in_record_start (in_record_start),
    .win_len         (win_len_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  kcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  kcf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .threshold        (threshold_r),
    .hash_seed        (hash_seed_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kmer_code    (out_kmer_code),
    .out_hash         (out_hash),
    .out_is_selected  (out_is_selected),
    .out_is_ambiguous (out_is_ambiguous)
  );

endmodule

/* tb/sv/canonical_kmer_fracminhash_filter_chk.sv */
// Checker for the canonical k-mer FracMinHash filter: predicts window results and compares.
module canonical_kmer_fracminhash_filter_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_base_char,
  input  logic        in_record_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_kmer_code,
  input  logic [63:0] out_hash,
  input  logic        out_is_selected,
  input  logic        out_is_ambiguous,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] kmer;
    logic [63:0] hash;
    logic        sel;
    logic        amb;
  } window_result_t;

  window_result_t window_q[$];
  logic [5:0]  win_len;
  logic [63:0] sel_limit;
  logic [63:0] seed;
  logic [63:0] fwd_win;
  logic [63:0] rc_win;
  int          rec_cnt;
  int          clean_cnt;

  assign pending = window_q.size();

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] fmix(input logic [63:0] x);
    x ^= x >> 33;
    x *= kcf_pkg::MM_F1;
    x ^= x >> 33;
    x *= kcf_pkg::MM_F2;
    x ^= x >> 33;
    return x;
  endfunction

  function automatic logic [63:0] murmur_lo(input logic [7:0] bytes[32], input int len,
                                            input logic [31:0] sd);
    logic [63:0] h1, h2, a, b;
    int blk, tl;
    h1 = {32'd0, sd};
    h2 = {32'd0, sd};
    blk = len / 16;
    tl = len % 16;
    for (int i = 0; i < blk; i++) begin
      a = 0;
      b = 0;
      for (int j = 0; j < 8; j++) begin
        a |= 64'(bytes[16*i+j]) << (8*j);
        b |= 64'(bytes[16*i+8+j]) << (8*j);
      end
      a *= kcf_pkg::MM_C1; a = rotl(a, 31); a *= kcf_pkg::MM_C2; h1 ^= a;
      h1 = rotl(h1, 27); h1 += h2; h1 = h1 * 5 + kcf_pkg::MM_N1;
      b *= kcf_pkg::MM_C2; b = rotl(b, 33); b *= kcf_pkg::MM_C1; h2 ^= b;
      h2 = rotl(h2, 31); h2 += h1; h2 = h2 * 5 + kcf_pkg::MM_N2;
    end
    if (tl > 8) begin
      b = 0;
      for (int i = 8; i < tl; i++) b |= 64'(bytes[16*blk+i]) << (8*(i-8));
      b *= kcf_pkg::MM_C2; b = rotl(b, 33); b *= kcf_pkg::MM_C1; h2 ^= b;
    end
    if (tl > 0) begin
      a = 0;
      for (int i = 0; i < tl && i < 8; i++) a |= 64'(bytes[16*blk+i]) << (8*i);
      a *= kcf_pkg::MM_C1; a = rotl(a, 31); a *= kcf_pkg::MM_C2; h1 ^= a;
    end
    h1 ^= 64'(len);
    h2 ^= 64'(len);
    h1 += h2;
    h2 += h1;
    h1 = fmix(h1);
    h2 = fmix(h2);
    return h1 + h2;
  endfunction

  task automatic predict_window(input logic [7:0] ch, input logic rs);
    window_result_t r;
    logic [7:0] c;
    logic [7:0] bytes[32];
    logic [63:0] fw, rc, cn;
    logic [1:0] code;
    logic ok;
    int k;
    k = (win_len == 0) ? 1 : (win_len > 32 ? 32 : int'(win_len));
    c = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    ok = 1'b1;
    case (c)
      "A": code = 2'd0;
      "C": code = 2'd1;
      "G": code = 2'd2;
      "T": code = 2'd3;
      default: begin
        code = 2'd0;
        ok = 1'b0;
      end
    endcase
    if (rs) begin
      fwd_win = 0;
      rc_win = 0;
      rec_cnt = 0;
      clean_cnt = 0;
    end
    fwd_win = (fwd_win << 2) | 64'(code);
    rc_win = (rc_win >> 2) | (64'(2'd3 - code) << 62);
    rec_cnt = (rec_cnt + 1 < k) ? rec_cnt + 1 : k;
    clean_cnt = ok ? ((clean_cnt + 1 < k) ? clean_cnt + 1 : k) : 0;
    if (rec_cnt < k) return;
    if (clean_cnt < k) begin
      r = '{64'd0, 64'd0, 1'b0, 1'b1};
    end else begin
      fw = (k >= 32) ? fwd_win : fwd_win & ((64'd1 << (2*k)) - 1);
      rc = rc_win >> (64 - 2*k);
      cn = (rc < fw) ? rc : fw;
      for (int i = 0; i < 32; i++) bytes[i] = 8'd0;
      for (int i = 0; i < k; i++)
        bytes[i] = kcf_pkg::base_letter(2'((cn >> (2*(k-1-i))) & 3));
      r.kmer = cn;
      r.hash = murmur_lo(bytes, k, seed[31:0]);
      r.sel = (r.hash <= sel_limit);
      r.amb = 1'b0;
    end
    window_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    window_result_t e;
    if (!rst_n) begin
      win_len <= kcf_pkg::WIN_LEN_RST;
      sel_limit <= kcf_pkg::THRESHOLD_RST;
      seed <= kcf_pkg::HASH_SEED_RST;
      fwd_win = 0;
      rc_win = 0;
      rec_cnt = 0;
      clean_cnt = 0;
      fail_count = 0;
      window_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          kcf_pkg::REG_WIN_LEN:   win_len <= cfg_wdata[5:0];
          kcf_pkg::REG_THRESHOLD: sel_limit <= cfg_wdata;
          kcf_pkg::REG_HASH_SEED: seed <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (window_q.size() == 0) begin
          report_mismatch("unexpected result kmer", out_kmer_code, 64'd0);
        end else begin
          e = window_q.pop_front();
          if (out_kmer_code !== e.kmer) report_mismatch("kmer_code", out_kmer_code, e.kmer);
          if (out_hash !== e.hash) report_mismatch("hash", out_hash, e.hash);
          if (out_is_selected !== e.sel)
            report_mismatch("is_selected", 64'(out_is_selected), 64'(e.sel));
          if (out_is_ambiguous !== e.amb)
            report_mismatch("is_ambiguous", 64'(out_is_ambiguous), 64'(e.amb));
        end
      end
      if (in_valid && !in_stall) predict_window(in_base_char, in_record_start);
    end
  end
endmodule

/* tb/sv/canonical_kmer_fracminhash_filter_tb.sv */
// Testbench top for the canonical k-mer FracMinHash filter: stimulus, idling phases, verdict.
module canonical_kmer_fracminhash_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_base_char = 8'd0;
  logic        in_record_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_kmer_code;
  logic [63:0] out_hash;
  logic        out_is_selected;
  logic        out_is_ambiguous;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = kcf_pkg::REG_WIN_LEN;
  logic [63:0] cfg_wdata = 64'd0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;

  always #1 clk = ~clk;

  canonical_kmer_fracminhash_filter u_top (.*);

  canonical_kmer_fracminhash_filter_chk u_chk (.*);

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #3000000;
    $display("canonical_kmer_fracminhash_filter: mismatch");
    $finish;
  end

  task automatic send_base(input logic [7:0] ch, input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_char <= ch;
    in_record_start <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_base();
    int r;
    logic [7:0] acgt[4];
    acgt = '{"A", "C", "G", "T"};
    r = $urandom_range(99);
    if (r < 80) return acgt[$urandom_range(3)];
    if (r < 93) return acgt[$urandom_range(3)] + 8'd32;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_records(input int n, input int rec_max);
    int left;
    left = 0;
    for (int i = 0; i < n; i++) begin
      send_base(rand_base(), left == 0);
      left = (left == 0) ? $urandom_range(rec_max) : left - 1;
    end
  endtask

  initial begin
    logic [7:0] dir[$];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: lowercase, ambiguity, extremes of char, record restarts at k=4
    write_reg(kcf_pkg::REG_WIN_LEN, 64'd4);
    write_reg(kcf_pkg::REG_THRESHOLD, 64'hffff_ffff_ffff_ffff);
    write_reg(kcf_pkg::REG_HASH_SEED, 64'hffff_ffff_ffff_ffff);
    dir = '{"A", "c", "g", "T", "t", "N", "A", "C", "G", 8'hff, "T", "G", "C", "A", 8'h00,
            "a", "a", "a", "a", "T", "T", "T", "T", "z"};
    foreach (dir[i]) send_base(dir[i], i == 0 || i == 15);
    drain();
    write_reg(kcf_pkg::REG_WIN_LEN, 64'd0);
    write_reg(kcf_pkg::REG_THRESHOLD, 64'd0);
    send_records(20, 10);
    drain();
    write_reg(kcf_pkg::REG_WIN_LEN, 64'd63);
    write_reg(kcf_pkg::REG_THRESHOLD, 64'h8000_0000_0000_0000);
    write_reg(kcf_pkg::REG_HASH_SEED, 64'h1234_5678_9abc_def0);
    send_records(80, 60);
    drain();
    // long receiver hold-off while the sender keeps pushing
    write_reg(kcf_pkg::REG_WIN_LEN, 64'd5);
    hold_off <= 400;
    send_records(60, 50);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 55 : 16) : 0;
      recv_stall_pct = (ph == 2) ? 55 : ((ph == 3) ? 16 : 0);
      write_reg(kcf_pkg::REG_WIN_LEN, 64'($urandom_range(1, 32)));
      write_reg(kcf_pkg::REG_THRESHOLD, {$urandom, $urandom});
      write_reg(kcf_pkg::REG_HASH_SEED, {$urandom, $urandom});
      send_records(150, 40);
      drain();
      write_reg(kcf_pkg::REG_WIN_LEN, 64'($urandom_range(1, 8)));
      send_records(120, 20);
      drain();
    end
    write_reg(kcf_pkg::REG_WIN_LEN, 64'd32);
    write_reg(kcf_pkg::REG_THRESHOLD, 64'd18446744073709552);
    write_reg(kcf_pkg::REG_HASH_SEED, 64'd42);
    send_records(60, 70);
    drain();
    if (fail_count == 0)
      $display("canonical_kmer_fracminhash_filter: match");
    else
      $display("canonical_kmer_fracminhash_filter: mismatch");
    $finish;
  end
endmodule
